// ===== design/queued_pulse_train_generator_unit_macros.svh =====
// Assertion macros for the queued pulse train generator.
`ifndef QUEUED_PULSE_TRAIN_GENERATOR_UNIT_MACROS_SVH
`define QUEUED_PULSE_TRAIN_GENERATOR_UNIT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define QPTG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qptg check failed");

// Check that a condition implies another in the next cycle.
`define QPTG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qptg check failed");

`endif

// ===== design/qptg_pkg.sv =====
// Types and constants shared by the queued pulse train generator.
package qptg_pkg;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_PUSH = 2'd1;
    localparam logic [1:0] OP_DROP = 2'd2;

    localparam logic [7:0] ENDLESS_RESET = 8'd255;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  channel;
        logic [15:0] pulse_width;
        logic [15:0] pulse_period;
        logic [7:0]  pulse_count;
    } qptg_req_t;

    typedef struct packed {
        logic [7:0] pin_levels;
        logic [7:0] active_mask;
        logic       accepted;
    } qptg_rsp_t;

    typedef struct packed {
        logic [15:0] w;
        logic [15:0] p;
        logic [7:0]  n;
    } qptg_job_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_TICK = 2'b10
    } qptg_state_t;

endpackage

// ===== design/queued_pulse_train_generator_unit.sv =====
// Top level of the queued pulse train generator.
//
// Push and drop requests finish at the accepting edge: the result strobes on done in the next
// cycle, and busy stays low, so such requests can be issued every cycle. A tick walks the
// channels one per cycle through the single job store read port and the shared timer update,
// so it keeps busy high until the last channel has been visited, and done strobes in the
// first cycle with busy low again. Results cannot be held off: rsp is valid for exactly the
// cycle in which done is high. The configuration port is always ready.
`include "queued_pulse_train_generator_unit_macros.svh"

module queued_pulse_train_generator_unit
    import qptg_pkg::*;
#(
    parameter int CHANNELS    = 8,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  qptg_req_t req,
    output logic      done,
    output qptg_rsp_t rsp,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [7:0] cfg_data
);

    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HEAD_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRIES = CHANNELS * QUEUE_DEPTH;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    qptg_state_t       state_reg, state_next;
    logic [CH_W-1:0]   proc_ch_reg;
    logic [7:0]        endless_reg;
    logic              done_reg;
    logic              acc_reg;

    logic [HEAD_W-1:0]  head_reg  [CHANNELS];
    logic [HEAD_W-1:0]  tail_reg  [CHANNELS];
    logic [COUNT_W-1:0] count_reg [CHANNELS];
    logic [15:0]        timer_reg [CHANNELS];
    logic [CHANNELS-1:0] pin_reg;

    qptg_job_t job_store_reg [ENTRIES];
    qptg_job_t rd_data_reg;

    logic              accept;
    logic [CH_W-1:0]   cmd_ch;
    logic              ch_ok;
    logic              push_ok;
    logic              drop_ok;
    logic              last_ch;
    logic [CH_W-1:0]   nxt_ch;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] proc_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    qptg_job_t         mem_wd;

    logic              tk_live;
    logic              tk_first;
    logic              tk_at_p;
    logic              tk_endless;
    logic [7:0]        tk_n_dec;
    logic              tk_pop;
    logic              tk_write;
    logic              tk_pin;
    logic [15:0]       tk_timer;

    function automatic logic [ADDR_W-1:0] slot(input logic [CH_W-1:0] ch,
                                               input logic [HEAD_W-1:0] pos);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(ch) * ADDR_W'(QUEUE_DEPTH);
        return base + ADDR_W'(pos);
    endfunction

    function automatic logic [HEAD_W-1:0] wrap_inc(input logic [HEAD_W-1:0] pos);
        logic [HEAD_W-1:0] res;
        if (pos == HEAD_W'(QUEUE_DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = pos + HEAD_W'(1);
        end
        return res;
    endfunction

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;

    assign cmd_ch  = CH_W'(req.channel);
    assign ch_ok   = (32'(req.channel) < CHANNELS);
    assign push_ok = ch_ok && (req.pulse_count != 8'd0) && (req.pulse_period != 16'd0)
                     && (count_reg[cmd_ch] < COUNT_W'(QUEUE_DEPTH));
    assign drop_ok = ch_ok && (count_reg[cmd_ch] != '0);

    assign last_ch = (proc_ch_reg == CH_W'(CHANNELS - 1));
    assign nxt_ch  = last_ch ? '0 : proc_ch_reg + CH_W'(1);

    // Prefetch the head job of the next channel to visit.
    always_comb
    begin
        if (state_reg == S_TICK)
        begin
            rd_addr = slot(nxt_ch, head_reg[nxt_ch]);
        end
        else
        begin
            rd_addr = slot('0, head_reg[0]);
        end
    end

    assign proc_addr = slot(proc_ch_reg, head_reg[proc_ch_reg]);

    // Per-channel tick step on the prefetched head job.
    always_comb
    begin
        tk_live    = (count_reg[proc_ch_reg] != '0) && (rd_data_reg.n != 8'd0);
        tk_first   = (timer_reg[proc_ch_reg] == 16'd0);
        tk_at_p    = (timer_reg[proc_ch_reg] == rd_data_reg.p);
        tk_endless = (rd_data_reg.n == endless_reg);
        tk_n_dec   = rd_data_reg.n - 8'd1;
        tk_pop     = 1'b0;
        tk_write   = 1'b0;
        tk_pin     = pin_reg[proc_ch_reg];
        tk_timer   = timer_reg[proc_ch_reg];
        if (tk_live)
        begin
            if (tk_first)
            begin
                tk_timer = 16'd1;
                tk_pin   = 1'b1;
            end
            else
            begin
                if (timer_reg[proc_ch_reg] == rd_data_reg.w)
                begin
                    tk_pin = 1'b0;
                end
                if (tk_at_p)
                begin
                    tk_timer = 16'd1;
                    if (tk_endless)
                    begin
                        tk_pin = 1'b1;
                    end
                    else
                    begin
                        tk_write = 1'b1;
                        if (tk_n_dec != 8'd0)
                        begin
                            tk_pin = 1'b1;
                        end
                        else
                        begin
                            tk_pin   = 1'b0;
                            tk_pop   = 1'b1;
                            tk_timer = 16'd0;
                        end
                    end
                end
                else
                begin
                    tk_timer = timer_reg[proc_ch_reg] + 16'd1;
                end
            end
        end
    end

    // Share the store write port between push and count update.
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = proc_addr;
        mem_wd = '{w: rd_data_reg.w, p: rd_data_reg.p, n: tk_n_dec};
        if (state_reg == S_TICK)
        begin
            mem_we = tk_write && !tk_pop;
        end
        else if (accept && (req.op == OP_PUSH) && push_ok)
        begin
            mem_we = 1'b1;
            mem_wa = slot(cmd_ch, tail_reg[cmd_ch]);
            mem_wd = '{w: req.pulse_width, p: req.pulse_period, n: req.pulse_count};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            job_store_reg[mem_wa] <= mem_wd;
        end
        rd_data_reg <= job_store_reg[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (req.op == OP_TICK))
                begin
                    state_next = S_TICK;
                end
            end
            S_TICK:
            begin
                if (last_ch)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            proc_ch_reg <= '0;
            endless_reg <= ENDLESS_RESET;
            done_reg    <= 1'b0;
            acc_reg     <= 1'b0;
            pin_reg     <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
                timer_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                endless_reg <= cfg_data;
            end
            if (state_reg == S_TICK)
            begin
                proc_ch_reg            <= nxt_ch;
                pin_reg[proc_ch_reg]   <= tk_pin;
                timer_reg[proc_ch_reg] <= tk_timer;
                if (tk_pop)
                begin
                    head_reg[proc_ch_reg]  <= wrap_inc(head_reg[proc_ch_reg]);
                    count_reg[proc_ch_reg] <= count_reg[proc_ch_reg] - COUNT_W'(1);
                end
                if (last_ch)
                begin
                    done_reg <= 1'b1;
                    acc_reg  <= 1'b0;
                end
            end
            else if (accept)
            begin
                proc_ch_reg <= '0;
                acc_reg     <= 1'b0;
                unique case (req.op)
                    OP_TICK:
                    begin
                    end
                    OP_PUSH:
                    begin
                        done_reg <= 1'b1;
                        if (push_ok)
                        begin
                            acc_reg           <= 1'b1;
                            tail_reg[cmd_ch]  <= wrap_inc(tail_reg[cmd_ch]);
                            count_reg[cmd_ch] <= count_reg[cmd_ch] + COUNT_W'(1);
                        end
                    end
                    OP_DROP:
                    begin
                        done_reg <= 1'b1;
                        if (drop_ok)
                        begin
                            acc_reg           <= 1'b1;
                            head_reg[cmd_ch]  <= wrap_inc(head_reg[cmd_ch]);
                            count_reg[cmd_ch] <= count_reg[cmd_ch] - COUNT_W'(1);
                            timer_reg[cmd_ch] <= '0;
                        end
                    end
                    default:
                    begin
                        done_reg <= 1'b1;
                    end
                endcase
            end
        end
    end

    // Expose pins and queue occupancy of the first eight channels.
    always_comb
    begin
        rsp.pin_levels  = '0;
        rsp.active_mask = '0;
        rsp.accepted    = acc_reg;
        for (int i = 0; i < 8; i++)
        begin
            if (i < CHANNELS)
            begin
                rsp.pin_levels[i]  = pin_reg[i];
                rsp.active_mask[i] = (count_reg[i] != '0);
            end
        end
    end

    `QPTG_ASSERT_IMP(a_state_onehot, 1'b1, $onehot(state_reg))
    `QPTG_ASSERT_IMP(a_no_done_in_tick, state_reg == S_TICK, !done_reg)
    `QPTG_ASSERT_IMP(a_tick_end_done, $fell(busy), done_reg)
    `QPTG_ASSERT_NXT(a_tick_runs, accept && (req.op == OP_TICK), busy && (proc_ch_reg == '0))

endmodule
